// ===== rtl/fragment_reassembly_tracker_macros.svh =====
// Assertion macros shared by the tracker RTL.
// Depends on nothing; included by modules that assert.
`ifndef FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
`define FRAGMENT_REASSEMBLY_TRACKER_MACROS_SVH
// implication checked each clock, off during reset
`define FRT_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define FRT_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/frt_pkg.sv =====
// Package for the fragment reassembly tracker: sizes, codes, field types.
// No dependencies.
package frt_pkg;
  localparam int MaxPending  = 24;
  localparam int Slots       = MaxPending + 1;
  localparam int SlotW       = 5;
  localparam int MaxChunks   = 2048;
  localparam int ChunkW      = 11;
  localparam int MaxFrame    = 2097152;
  localparam int HeaderBytes = 20;
  localparam int TotalW      = 27;
  localparam int EntW        = SlotW + 1;       // stream + slot
  localparam logic [31:0] MagicLcu1 = 32'h4C435531;
  localparam logic [7:0]  TagAudio  = 8'h41;
  localparam logic [7:0]  TagVideo  = 8'h56;

  typedef enum logic [3:0] {
    ST_BAD_HDR = 4'd0, ST_LOOP = 4'd1, ST_BAD_IDX = 4'd2, ST_LEN = 4'd3,
    ST_TOO_MANY = 4'd4, ST_CNT = 4'd5, ST_STORED = 4'd6, ST_DUP = 4'd7,
    ST_OVERSIZE = 4'd8, ST_DONE = 4'd9
  } status_t;

  typedef struct packed {
    logic        stream;
    logic [15:0] datagram_len;
    logic [31:0] header_magic;
    logic [7:0]  media_tag;
    logic [7:0]  version_byte;
    logic [15:0] chunk_index;
    logic [15:0] chunk_count;
    logic [31:0] frame_id;
    logic [15:0] chunk_len;
    logic [31:0] sender_token;
  } hdr_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [4:0]  slot;
    logic        store_payload;
    logic        evicted;
    logic [31:0] evicted_frame_id;
    logic [21:0] total_bytes;
  } res_t;

  // entry record kept in RAM: frame id, expected, received, total
  typedef struct packed {
    logic [31:0]       fid;
    logic [15:0]       expected;
    logic [15:0]       received;
    logic [TotalW-1:0] total;
  } entry_t;
endpackage

// ===== rtl/frt_if.sv =====
// Valid/ready channel interfaces for headers and results.
// Depends on frt_pkg.
interface frt_hdr_if (input logic clk);
  import frt_pkg::*;
  logic valid;
  logic ready;
  hdr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frt_res_if (input logic clk);
  import frt_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/frt_ram.sv =====
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module frt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/fragment_reassembly_tracker.sv =====
// Top level of the fragment reassembly tracker.
// Depends on frt_pkg, frt_if, frt_ram and the macros header.
//
// One header is taken at a time; the block is not ready again until the result has
// been taken. A header that fails the format, loopback, index, length or count checks
// passes through the check and output states before its result is offered. A header
// that reaches the table scans the 25 slots of its stream through the entry RAM, one
// slot per cycle with a registered read, then reads the bitmap word and writes back.
// A new frame also wipes its bitmap row, and an eviction scan of a full stream comes
// ahead of the lookup. The table scan and the row wipe set the rate. After reset a
// clearing pass zeroes the whole bitmap, one 32-bit word per cycle over 2 x 32 x 64
// words, before the first header is taken. Status, slot, eviction and total appear
// on the result channel, held in an output register until taken.
`include "fragment_reassembly_tracker_macros.svh"
module fragment_reassembly_tracker (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic [31:0] cfg_wdata,
  frt_hdr_if.sink   hdr,
  frt_res_if.source res
);
  import frt_pkg::*;

  localparam int WordW  = 32;
  localparam int WordsPerRow = MaxChunks / WordW;          // 64
  localparam int WselW  = $clog2(WordsPerRow);
  localparam int BwAw   = EntW + WselW;                     // bitmap word address
  localparam int BwDepth = 2 * 32 * WordsPerRow;
  localparam int BitSelW = $clog2(WordW);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_EVSCAN, S_EVDONE, S_LOOK, S_ALLOC,
    S_WIPE, S_BREAD, S_BWAIT, S_UPD, S_OUT
  } state_t;

  state_t state;
  logic [31:0] local_token;
  hdr_t h;
  res_t r;
  logic rvalid;

  logic [Slots-1:0] valid_a, valid_v;
  logic [SlotW:0]   pend_a, pend_v;

  // entry RAM
  logic            e_we;
  logic [EntW-1:0] e_waddr, e_raddr;
  entry_t          e_wdata, e_rdata;
  frt_ram #(.Width($bits(entry_t)), .Depth(64)) u_ent (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));

  // bitmap RAM, 32-bit words
  logic             b_we;
  logic [BwAw-1:0]  b_waddr, b_raddr;
  logic [WordW-1:0] b_wdata, b_rdata;
  frt_ram #(.Width(WordW), .Depth(BwDepth)) u_bits (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));

  // scan state
  logic [SlotW-1:0] scan, scan_d, best, slot, free_slot;
  logic             have, scan_live, found, have_free;
  logic [31:0]      best_id;
  logic [BwAw-1:0]  clr;
  logic [WselW:0]   wipe;
  entry_t           ent;

  logic [Slots-1:0] cur_valid;
  assign cur_valid = h.stream ? valid_v : valid_a;
  logic [SlotW:0] cur_pend;
  assign cur_pend = h.stream ? pend_v : pend_a;

  // header checks on the latched request
  logic bad_hdr, loopback, bad_idx, bad_len, too_many;
  always_comb begin
    bad_hdr  = h.datagram_len < 16'(HeaderBytes) || h.header_magic != MagicLcu1 ||
               h.media_tag != (h.stream ? TagVideo : TagAudio) || h.version_byte != 8'd1;
    loopback = h.sender_token != '0 && h.sender_token == local_token;
    bad_idx  = h.chunk_count == '0 || h.chunk_index >= h.chunk_count;
    bad_len  = {1'b0, h.datagram_len} != 17'(HeaderBytes) + {1'b0, h.chunk_len};
    too_many = h.chunk_count > 16'(MaxChunks);
  end

  logic [TotalW:0] tsum;
  logic [TotalW-1:0] tsat;
  always_comb begin
    tsum = {1'b0, ent.total} + (TotalW+1)'(h.chunk_len);
    tsat = tsum[TotalW] ? '1 : tsum[TotalW-1:0];
  end
  logic [BitSelW-1:0] bsel;
  assign bsel = h.chunk_index[BitSelW-1:0];
  logic [WselW-1:0] wsel;
  assign wsel = h.chunk_index[ChunkW-1:BitSelW];

  assign hdr.ready = state == S_IDLE && !rvalid;
  assign res.valid = rvalid;
  assign res.data  = r;

  // clear one valid bit of the current stream
  function automatic logic [Slots-1:0] clr_bit(logic [Slots-1:0] v, logic [SlotW-1:0] k);
    logic [Slots-1:0] o;
    o = v;
    o[k] = 1'b0;
    return o;
  endfunction

  // RAM port drive
  always_comb begin
    e_raddr = {h.stream, scan};
    e_we    = 1'b0;
    e_waddr = {h.stream, slot};
    e_wdata = ent;
    b_we    = 1'b0;
    b_waddr = clr;
    b_wdata = '0;
    b_raddr = {h.stream, slot, wsel};
    unique case (state)
      S_CLEAR: b_we = 1'b1;
      S_WIPE: begin
        b_we = 1'b1;
        b_waddr = {h.stream, slot, wipe[WselW-1:0]};
      end
      S_UPD: begin
        // a duplicate chunk leaves both the entry and the bitmap untouched
        e_we = !b_rdata[bsel];
        b_we = !b_rdata[bsel];
        b_waddr = {h.stream, slot, wsel};
        b_wdata = b_rdata | (WordW'(1) << bsel);
        e_wdata = '{fid: ent.fid, expected: ent.expected,
                    received: ent.received + 16'd1, total: tsat};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      local_token <= 32'd1;
      valid_a <= '0;
      valid_v <= '0;
      pend_a <= '0;
      pend_v <= '0;
      rvalid <= 1'b0;
      clr <= '0;
    end else begin
      if (cfg_we) local_token <= cfg_wdata;
      if (res.valid && res.ready) rvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + BwAw'(1);
          if (clr == BwAw'(BwDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: if (hdr.valid && hdr.ready) begin
          h <= hdr.data;
          r <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          scan <= '0;
          scan_live <= 1'b0;
          have <= 1'b0;
          found <= 1'b0;
          have_free <= 1'b0;
          if (bad_hdr) begin
            r.status <= ST_BAD_HDR; state <= S_OUT;
          end else if (loopback) begin
            r.status <= ST_LOOP; state <= S_OUT;
          end else if (bad_idx) begin
            r.status <= ST_BAD_IDX; state <= S_OUT;
          end else if (bad_len) begin
            r.status <= ST_LEN; state <= S_OUT;
          end else if (too_many) begin
            r.status <= ST_TOO_MANY; state <= S_OUT;
          end else begin
            state <= cur_pend > (SlotW+1)'(MaxPending) ? S_EVSCAN : S_LOOK;
          end
        end
        // min frame id search, one slot read per cycle
        S_EVSCAN: begin
          scan_d <= scan;
          scan_live <= scan != SlotW'(Slots);
          if (scan != SlotW'(Slots)) scan <= scan + SlotW'(1);
          if (scan_live && cur_valid[scan_d] && (!have || e_rdata.fid < best_id)) begin
            have <= 1'b1; best <= scan_d; best_id <= e_rdata.fid;
          end
          if (scan_live && scan_d == SlotW'(Slots - 1)) state <= S_EVDONE;
        end
        S_EVDONE: begin
          if (have) begin
            r.evicted <= 1'b1;
            r.evicted_frame_id <= best_id;
            if (h.stream) begin
              valid_v <= clr_bit(valid_v, best); pend_v <= pend_v - (SlotW+1)'(1);
            end else begin
              valid_a <= clr_bit(valid_a, best); pend_a <= pend_a - (SlotW+1)'(1);
            end
          end
          scan <= '0;
          scan_live <= 1'b0;
          state <= S_LOOK;
        end
        // match search plus lowest free slot
        S_LOOK: begin
          scan_d <= scan;
          scan_live <= scan != SlotW'(Slots);
          if (scan != SlotW'(Slots)) scan <= scan + SlotW'(1);
          if (scan_live && !found) begin
            if (cur_valid[scan_d] && e_rdata.fid == h.frame_id) begin
              found <= 1'b1; slot <= scan_d; ent <= e_rdata;
            end else if (!cur_valid[scan_d] && !have_free) begin
              have_free <= 1'b1; free_slot <= scan_d;
            end
          end
          if (scan_live && scan_d == SlotW'(Slots - 1)) state <= S_ALLOC;
        end
        S_ALLOC: begin
          wipe <= '0;
          if (found) begin
            state <= S_BREAD;
          end else begin
            slot <= free_slot;
            ent <= '{fid: h.frame_id, expected: h.chunk_count, received: '0, total: '0};
            if (h.stream) begin
              valid_v[free_slot] <= 1'b1; pend_v <= pend_v + (SlotW+1)'(1);
            end else begin
              valid_a[free_slot] <= 1'b1; pend_a <= pend_a + (SlotW+1)'(1);
            end
            state <= S_WIPE;
          end
        end
        S_WIPE: begin
          wipe <= wipe + (WselW+1)'(1);
          if (wipe == (WselW+1)'(WordsPerRow - 1)) state <= S_BREAD;
        end
        S_BREAD: begin
          r.slot <= slot;
          if (ent.expected != h.chunk_count) begin
            r.status <= ST_CNT;
            if (h.stream) begin
              valid_v <= clr_bit(valid_v, slot); pend_v <= pend_v - (SlotW+1)'(1);
            end else begin
              valid_a <= clr_bit(valid_a, slot); pend_a <= pend_a - (SlotW+1)'(1);
            end
            state <= S_OUT;
          end else begin
            state <= S_BWAIT;
          end
        end
        S_BWAIT: state <= S_UPD;
        S_UPD: begin
          if (b_rdata[bsel]) begin
            r.status <= ST_DUP;
          end else if (ent.received + 16'd1 != ent.expected) begin
            r.status <= ST_STORED;
            r.store_payload <= 1'b1;
          end else begin
            if (tsat == '0 || tsat > TotalW'(MaxFrame)) begin
              r.status <= ST_OVERSIZE;
            end else begin
              r.status <= ST_DONE;
              r.store_payload <= 1'b1;
              r.total_bytes <= tsat[21:0];
            end
            if (h.stream) begin
              valid_v <= clr_bit(valid_v, slot); pend_v <= pend_v - (SlotW+1)'(1);
            end else begin
              valid_a <= clr_bit(valid_a, slot); pend_a <= pend_a - (SlotW+1)'(1);
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          rvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FRT_ASSERT_IMP(a_pend_bound_a, clk, rst, 1'b1, pend_a <= (SlotW+1)'(Slots))
  `FRT_ASSERT_IMP(a_pend_bound_v, clk, rst, 1'b1, pend_v <= (SlotW+1)'(Slots))
  `FRT_ASSERT_IMP(a_pend_cnt, clk, rst, state == S_IDLE, pend_a == (SlotW+1)'($countones(valid_a)))
  `FRT_ASSERT_IMP(a_alloc_free, clk, rst, state == S_ALLOC && !found, have_free)
  `FRT_ASSERT_NEXT(a_out_valid, clk, rst, state == S_OUT, rvalid)
endmodule
